@@ rtl/core/cfs_pkg.sv @@
// Package: shared types, constants and the field index limit for the CSV field splitter.
`default_nettype none

package cfs_pkg;

   // Field count limit; the index saturates at FIELD_CAP
   localparam int unsigned MAX_FIELDS = 32;
   localparam int unsigned FIELD_IDX_W = 5;
   localparam logic [FIELD_IDX_W-1:0] FIELD_CAP =
      ((MAX_FIELDS - 1) > 31) ? 5'd31 : FIELD_IDX_W'(MAX_FIELDS - 1);

   // Special bytes
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_NL    = 8'h0A;

   // Input word
   typedef struct packed {
      logic [7:0] char_in;
      logic       end_of_text;
   } cfs_req_type;

   // Result word
   typedef struct packed {
      logic                   char_valid;
      logic [7:0]             char_out;
      logic [FIELD_IDX_W-1:0] field_index;
      logic                   field_end;
      logic                   record_end;
      logic                   field_overflow;
   } cfs_rsp_type;

   // Parser state
   typedef struct packed {
      logic                   in_header;
      logic                   in_quotes;
      logic                   quote_pending;
      logic                   field_start;
      logic [FIELD_IDX_W-1:0] field_count;
      logic                   overflow_seen;
   } cfs_state_type;

   // One step's outcome: whether a result word is produced, and the word
   typedef struct packed {
      logic        has;
      cfs_rsp_type rsp;
   } cfs_step_type;

endpackage

`default_nettype wire

@@ rtl/core/cfs_step.sv @@
// Combinational next-state and result logic for one input byte.
`default_nettype none

module cfs_step (
   input  cfs_pkg::cfs_state_type cur,
   input  cfs_pkg::cfs_req_type   req,
   input  logic                   skip_header,
   output cfs_pkg::cfs_state_type nxt,
   output cfs_pkg::cfs_step_type  res
);
   import cfs_pkg::*;

   logic plain;
   logic open_rec;

   always_comb begin
      nxt      = cur;
      plain    = 1'b0;
      open_rec = 1'b0;
      res.has  = 1'b0;
      res.rsp.char_valid     = 1'b0;
      res.rsp.char_out       = 8'h00;
      res.rsp.field_index    = cur.field_count;
      res.rsp.field_end      = 1'b0;
      res.rsp.record_end     = 1'b0;
      res.rsp.field_overflow = cur.overflow_seen;

      if (cur.in_header) begin
         // header line: dropped up to and including the first newline
         if (req.char_in == CH_NL) begin
            nxt.in_header = 1'b0;
         end
         if (req.end_of_text) begin
            nxt.in_header = skip_header;
         end
      end else begin
         if (cur.in_quotes) begin
            // quoted field: a quote closes or starts an escaped pair
            if (req.char_in == CH_QUOTE) begin
               nxt.in_quotes     = 1'b0;
               nxt.quote_pending = 1'b1;
            end else begin
               res.has            = 1'b1;
               res.rsp.char_valid = 1'b1;
               res.rsp.char_out   = req.char_in;
            end
         end else begin
            plain = 1'b1;
            // byte after a closing quote: doubled quote is a literal
            if (cur.quote_pending) begin
               nxt.quote_pending = 1'b0;
               if (req.char_in == CH_QUOTE) begin
                  nxt.in_quotes      = 1'b1;
                  res.has            = 1'b1;
                  res.rsp.char_valid = 1'b1;
                  res.rsp.char_out   = req.char_in;
                  plain              = 1'b0;
               end
            end
            if (plain) begin
               priority if (req.char_in == CH_COMMA) begin
                  res.has           = 1'b1;
                  res.rsp.field_end = 1'b1;
                  if (cur.field_count < FIELD_CAP) begin
                     nxt.field_count = cur.field_count + FIELD_IDX_W'(1);
                  end else begin
                     nxt.overflow_seen = 1'b1;
                  end
                  res.rsp.field_overflow = nxt.overflow_seen;
                  nxt.field_start        = 1'b1;
               end else if (req.char_in == CH_NL) begin
                  res.has            = 1'b1;
                  res.rsp.field_end  = 1'b1;
                  res.rsp.record_end = 1'b1;
                  nxt.field_count    = '0;
                  nxt.overflow_seen  = 1'b0;
                  nxt.field_start    = 1'b1;
               end else if (req.char_in == CH_QUOTE && cur.field_start) begin
                  nxt.in_quotes   = 1'b1;
                  nxt.field_start = 1'b0;
               end else begin
                  res.has            = 1'b1;
                  res.rsp.char_valid = 1'b1;
                  res.rsp.char_out   = req.char_in;
                  nxt.field_start    = 1'b0;
               end
            end
         end

         // end of text: close an open record, then return to start state
         if (req.end_of_text) begin
            open_rec = !(nxt.field_start && (nxt.field_count == '0) && !nxt.overflow_seen);
            if (open_rec) begin
               if (!res.has) begin
                  res.has                = 1'b1;
                  res.rsp.char_valid     = 1'b0;
                  res.rsp.char_out       = 8'h00;
                  res.rsp.field_index    = nxt.field_count;
                  res.rsp.field_overflow = nxt.overflow_seen;
               end
               res.rsp.field_end  = 1'b1;
               res.rsp.record_end = 1'b1;
            end
            nxt.in_quotes     = 1'b0;
            nxt.quote_pending = 1'b0;
            nxt.field_start   = 1'b1;
            nxt.field_count   = '0;
            nxt.overflow_seen = 1'b0;
            nxt.in_header     = skip_header;
         end
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/cfs_ctrl.sv @@
// Parser state registers, skip_header register and the step logic.
`default_nettype none

module cfs_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write,
   input  logic                  csr_data,
   input  logic                  go,
   input  cfs_pkg::cfs_req_type  req,
   output cfs_pkg::cfs_step_type res
);
   import cfs_pkg::*;

   logic          skip_header_ff;
   cfs_state_type state_ff;
   cfs_state_type state_in;

   // next state and result for the word in the input register
   cfs_step u_step (
      .cur         (state_ff),
      .req         (req),
      .skip_header (skip_header_ff),
      .nxt         (state_in),
      .res         (res)
   );

   // configuration and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         skip_header_ff          <= 1'b1;
         state_ff.in_header      <= 1'b1;
         state_ff.in_quotes      <= 1'b0;
         state_ff.quote_pending  <= 1'b0;
         state_ff.field_start    <= 1'b1;
         state_ff.field_count    <= '0;
         state_ff.overflow_seen  <= 1'b0;
      end else begin
         if (csr_write) begin
            skip_header_ff <= csr_data;
         end
         if (go) begin
            state_ff <= state_in;
         end
      end
   end

   // a closing quote is never pending inside an open quoted field
   a_quote_excl: assert property (@(posedge clock) disable iff (reset)
      !(state_ff.in_quotes && state_ff.quote_pending))
      else $error("in_quotes and quote_pending both set");

   // overflow only once the index has saturated
   a_ovf_cap: assert property (@(posedge clock) disable iff (reset)
      state_ff.overflow_seen |-> (state_ff.field_count == FIELD_CAP))
      else $error("overflow_seen below field cap");

   // end of text leaves the parser at the start of a record
   a_eot_clear: assert property (@(posedge clock) disable iff (reset)
      (go && req.end_of_text) |=>
         (!state_ff.in_quotes && !state_ff.quote_pending && state_ff.field_start
          && (state_ff.field_count == '0) && !state_ff.overflow_seen))
      else $error("state not cleared after end of text");

endmodule

`default_nettype wire

@@ rtl/core/csv_field_splitter.sv @@
// Top level: input register, CSV parser control and result register.
//
//  channel | direction | handshake            | word
//  req_    | in        | req_valid/req_stall  | cfs_req_type (char_in, end_of_text)
//  rsp_    | out       | rsp_valid/rsp_stall  | cfs_rsp_type (char, index, marks)
//  csr_    | in        | csr_valid/csr_ready  | skip_header bit
//
// One byte per cycle sustained while rsp_stall is low; a word reaches rsp through
// the input register, then the step logic into the result register.
// Bytes that yield no result (header, opening/closing quotes) only update state.
// Reset is synchronous; skip_header and the header flag come up as 1.
// rsp_stall holds the result register; the input register then fills and
// req_stall rises only when both are occupied.
`default_nettype none

module csv_field_splitter (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  cfs_pkg::cfs_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output cfs_pkg::cfs_rsp_type rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic                 csr_data
);
   import cfs_pkg::*;

   logic         in_valid_ff;
   cfs_req_type  in_data_ff;
   logic         rsp_valid_ff;
   cfs_rsp_type  rsp_data_ff;
   logic         go;
   logic         in_ready;
   cfs_step_type res;

   // advance when the result register is free or being drained
   assign go        = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign in_ready  = !in_valid_ff || go;
   assign req_stall = !in_ready;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   cfs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_valid),
      .csr_data  (csr_data),
      .go        (go),
      .req       (in_data_ff),
      .res       (res)
   );

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (in_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && in_ready) begin
         in_data_ff <= req_data;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (go) begin
         rsp_valid_ff <= res.has;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (go && res.has) begin
         rsp_data_ff <= res.rsp;
      end
   end

   // a record end always closes its field too
   a_rec_field: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.record_end) |-> rsp_data.field_end)
      else $error("record_end without field_end");

   // no content byte means a zero byte
   a_char_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.char_valid) |-> (rsp_data.char_out == 8'h00))
      else $error("char_out nonzero without char_valid");

   // a word without content must carry at least a field end
   a_rsp_marks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.char_valid || rsp_data.field_end))
      else $error("empty result word");

endmodule

`default_nettype wire

@@ tb/sv/tb_csv_field_splitter.sv @@
// Testbench for the CSV field splitter: directed and random byte streams checked by a predictor.
module tb_csv_field_splitter;
   timeunit 1ns;
   timeprecision 1ps;

   import cfs_pkg::*;

   localparam int LATENCY      = 2;
   localparam int HOLD_CYCLES  = 80;
   localparam int DRAIN_CYCLES = 20000;

   typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_e;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   cfs_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   cfs_rsp_type rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_data = 1'b0;

   // Predictor state and the words it still waits for
   cfs_state_type split_st;
   logic          skip_cfg;
   cfs_rsp_type   due_words[$];

   logic [7:0] text_buf[$];
   int         mismatches = 0;
   int         data_words = 0;
   int         burst_left = 0;
   bit         no_gaps = 1'b0;
   bit         hold_request = 1'b0;
   bit         hold_active = 1'b0;

   csv_field_splitter dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Splits one input byte and queues the word it yields, if any
   task automatic predict_split(input cfs_req_type w);
      cfs_rsp_type r;
      logic        has;
      logic        plain;
      logic        rec_open;
      r = '0;
      has = 1'b0;
      r.field_index = split_st.field_count;
      r.field_overflow = split_st.overflow_seen;
      if (split_st.in_header) begin
         if (w.char_in == CH_NL) split_st.in_header = 1'b0;
         if (w.end_of_text) split_st.in_header = skip_cfg;
      end else begin
         if (split_st.in_quotes) begin
            if (w.char_in == CH_QUOTE) begin
               split_st.in_quotes = 1'b0;
               split_st.quote_pending = 1'b1;
            end else begin
               has = 1'b1;
               r.char_valid = 1'b1;
               r.char_out = w.char_in;
            end
         end else begin
            plain = 1'b1;
            // doubled quote: literal quote, back inside the quoted field
            if (split_st.quote_pending) begin
               split_st.quote_pending = 1'b0;
               if (w.char_in == CH_QUOTE) begin
                  split_st.in_quotes = 1'b1;
                  has = 1'b1;
                  r.char_valid = 1'b1;
                  r.char_out = w.char_in;
                  plain = 1'b0;
               end
            end
            if (plain) begin
               if (w.char_in == CH_COMMA) begin
                  has = 1'b1;
                  r.field_end = 1'b1;
                  if (split_st.field_count < FIELD_CAP)
                     split_st.field_count = split_st.field_count + 1'b1;
                  else
                     split_st.overflow_seen = 1'b1;
                  r.field_overflow = split_st.overflow_seen;
                  split_st.field_start = 1'b1;
               end else if (w.char_in == CH_NL) begin
                  has = 1'b1;
                  r.field_end = 1'b1;
                  r.record_end = 1'b1;
                  split_st.field_count = '0;
                  split_st.overflow_seen = 1'b0;
                  split_st.field_start = 1'b1;
               end else if (w.char_in == CH_QUOTE && split_st.field_start) begin
                  split_st.in_quotes = 1'b1;
                  split_st.field_start = 1'b0;
               end else begin
                  has = 1'b1;
                  r.char_valid = 1'b1;
                  r.char_out = w.char_in;
                  split_st.field_start = 1'b0;
               end
            end
         end
         // end of text closes an open record and restarts the stream
         if (w.end_of_text) begin
            rec_open = !(split_st.field_start && split_st.field_count == 0
                         && !split_st.overflow_seen);
            if (rec_open) begin
               if (!has) begin
                  has = 1'b1;
                  r.field_index = split_st.field_count;
                  r.field_overflow = split_st.overflow_seen;
               end
               r.field_end = 1'b1;
               r.record_end = 1'b1;
            end
            split_st.in_quotes = 1'b0;
            split_st.quote_pending = 1'b0;
            split_st.field_start = 1'b1;
            split_st.field_count = '0;
            split_st.overflow_seen = 1'b0;
            split_st.in_header = skip_cfg;
         end
         if (has) due_words.push_back(r);
      end
   endtask

   // Sends one input word in bursts with random gaps
   task automatic send_word(input logic [7:0] ch, input logic eot);
      cfs_req_type w;
      int          gap;
      w.char_in = ch;
      w.end_of_text = eot;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 160)
                                                  : $urandom_range(1, 12);
         gap = no_gaps ? 0 : $urandom_range(0, 7);
         if (gap != 0) begin
            @(negedge clock);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (req_stall);
      if (!split_st.in_header) data_words++;
      predict_split(w);
      burst_left--;
   endtask

   task automatic send_text(input string s, input bit eot);
      for (int i = 0; i < s.len(); i++)
         send_word(s[i], eot && i == s.len() - 1);
   endtask

   task automatic send_buffered(input bit eot);
      foreach (text_buf[i])
         send_word(text_buf[i], eot && i == text_buf.size() - 1);
      text_buf.delete();
   endtask

   // Waits until every expected word is out, plus the pipeline depth
   task automatic settle_block();
      int waited;
      waited = 0;
      @(negedge clock);
      req_valid <= 1'b0;
      burst_left = 0;
      while (due_words.size() != 0 && waited < DRAIN_CYCLES) begin
         @(posedge clock);
         waited++;
      end
      repeat (LATENCY + 2) @(posedge clock);
   endtask

   task automatic write_skip_header(input logic value);
      settle_block();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      skip_cfg = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Content byte, biased toward the bytes the parser treats specially
   function automatic logic [7:0] pick_content(input bit quoted, input bit first);
      logic [7:0] c;
      case ($urandom_range(0, 7))
         0:       c = CH_COMMA;
         1:       c = CH_NL;
         2:       c = CH_QUOTE;
         default: c = 8'($urandom_range(0, 255));
      endcase
      if (!quoted && (c == CH_COMMA || c == CH_NL || (first && c == CH_QUOTE)))
         c = 8'($urandom_range(8'h30, 8'h7A));
      return c;
   endfunction

   function automatic void add_field(input bit quoted, input int len);
      logic [7:0] c;
      if (quoted) text_buf.push_back(CH_QUOTE);
      for (int i = 0; i < len; i++) begin
         c = pick_content(quoted, i == 0);
         text_buf.push_back(c);
         if (quoted && c == CH_QUOTE) text_buf.push_back(CH_QUOTE);
      end
      // now and then an unterminated quote, or junk after the closing quote
      if (quoted && $urandom_range(0, 29) != 0) text_buf.push_back(CH_QUOTE);
      if (quoted && $urandom_range(0, 15) == 0)
         text_buf.push_back(8'($urandom_range(8'h30, 8'h7A)));
   endfunction

   function automatic void add_record(input int nfields, input int maxlen);
      for (int f = 0; f < nfields; f++) begin
         if (f != 0) text_buf.push_back(CH_COMMA);
         add_field($urandom_range(0, 3) == 0, $urandom_range(0, maxlen));
      end
      text_buf.push_back(CH_NL);
   endfunction

   function automatic void add_header_if_due();
      logic [7:0] c;
      if (split_st.in_header) begin
         repeat ($urandom_range(0, 10)) begin
            c = pick_content(1'b1, 1'b0);
            text_buf.push_back(c == CH_NL ? CH_COMMA : c);
         end
         text_buf.push_back(CH_NL);
      end
   endfunction

   // Header line dropped, quote inside it ignored
   task automatic test_header_line();
      send_text("h\"\n", 1'b0);
   endtask

   // Quoted comma and newline, doubled quote, bytes after a closing quote,
   // quote inside an unquoted field
   task automatic test_quoting();
      send_text("\"a,\n\"\"\"c,d\"e\n", 1'b0);
   endtask

   task automatic test_byte_extremes();
      send_word(8'h00, 1'b0);
      send_word(8'hFF, 1'b0);
      send_word(CH_NL, 1'b0);
   endtask

   // End of text on a content byte, a comma, a closing quote, a newline,
   // inside an open quote and inside the header
   task automatic test_end_of_text();
      write_skip_header(1'b0);
      send_text("q", 1'b1);
      send_text(",", 1'b1);
      send_text("\"ab\"", 1'b1);
      send_text("\n", 1'b1);
      send_text("\"u", 1'b1);
      write_skip_header(1'b1);
      send_text("m", 1'b1);
      send_text("h", 1'b1);
   endtask

   // Mostly well-formed streams with random content, some noise
   task automatic test_random_streams(input int count);
      int goal;
      goal = data_words + count;
      while (data_words < goal) begin
         if ($urandom_range(0, 9) != 0) add_header_if_due();
         if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 20)) text_buf.push_back(pick_content(1'b1, 1'b0));
         end else begin
            repeat ($urandom_range(1, 4)) add_record($urandom_range(1, 6), 5);
            if ($urandom_range(0, 3) == 0) void'(text_buf.pop_back());
         end
         send_buffered($urandom_range(0, 2) == 0);
      end
   endtask

   // Records past the field index limit, one closed by end of text
   task automatic test_field_overflow();
      add_header_if_due();
      add_record(34, 1);
      add_record(40, 0);
      add_record(36, 1);
      void'(text_buf.pop_back());
      send_buffered(1'b1);
   endtask

   // Receiver holds off while the sender keeps offering words
   task automatic test_receiver_holdoff();
      no_gaps = 1'b1;
      add_header_if_due();
      repeat (4) add_record(4, 3);
      hold_request = 1'b1;
      send_buffered(1'b0);
      no_gaps = 1'b0;
   endtask

   // Long receiver hold-off, counted here
   initial begin
      forever begin
         wait (hold_request);
         hold_active = 1'b1;
         repeat (HOLD_CYCLES) @(posedge clock);
         hold_active = 1'b0;
         hold_request = 1'b0;
      end
   end

   // Receiver stall pattern, switching style every so often
   initial begin
      stall_mode_e mode;
      int          span;
      int          period;
      int          duty;
      logic        pattern;
      forever begin
         mode = stall_mode_e'($urandom_range(0, 3));
         span = $urandom_range(16, 160);
         period = $urandom_range(2, 7);
         duty = $urandom_range(1, period - 1);
         for (int k = 0; k < span; k++) begin
            @(negedge clock);
            case (mode)
               STALL_NONE:  pattern = 1'b0;
               STALL_LIGHT: pattern = ($urandom_range(0, 3) == 0);
               STALL_HEAVY: pattern = ($urandom_range(0, 3) != 0);
               default:     pattern = ((k % period) < duty);
            endcase
            rsp_stall <= hold_active || pattern;
         end
      end
   end

   // Result checker
   always @(posedge clock) begin
      cfs_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (due_words.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected word: cv=%0b ch=%02h idx=%0d fe=%0b re=%0b ovf=%0b",
                        rsp_data.char_valid, rsp_data.char_out, rsp_data.field_index,
                        rsp_data.field_end, rsp_data.record_end, rsp_data.field_overflow);
         end else begin
            want = due_words.pop_front();
            if (rsp_data.char_valid !== want.char_valid
                || rsp_data.char_out !== want.char_out
                || rsp_data.field_index !== want.field_index
                || rsp_data.field_end !== want.field_end
                || rsp_data.record_end !== want.record_end
                || rsp_data.field_overflow !== want.field_overflow) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("word mismatch at %0t:", $realtime);
                  $display("  got  cv=%0b ch=%02h idx=%0d fe=%0b re=%0b ovf=%0b",
                           rsp_data.char_valid, rsp_data.char_out, rsp_data.field_index,
                           rsp_data.field_end, rsp_data.record_end, rsp_data.field_overflow);
                  $display("  want cv=%0b ch=%02h idx=%0d fe=%0b re=%0b ovf=%0b",
                           want.char_valid, want.char_out, want.field_index,
                           want.field_end, want.record_end, want.field_overflow);
               end
            end
         end
      end
   end

   initial begin
      #2_000_000;
      $display("timeout: run did not finish");
      $display("FAIL csv_field_splitter");
      $finish;
   end

   initial begin
      skip_cfg = 1'b1;
      split_st = '{in_header: 1'b1, in_quotes: 1'b0, quote_pending: 1'b0,
                   field_start: 1'b1, field_count: '0, overflow_seen: 1'b0};
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_header_line();
      test_quoting();
      test_byte_extremes();
      test_end_of_text();
      test_random_streams(150);
      test_field_overflow();
      test_receiver_holdoff();
      write_skip_header(1'b0);
      send_text("x", 1'b1);
      test_random_streams(150);
      test_receiver_holdoff();
      write_skip_header(1'b1);
      test_random_streams(80);

      settle_block();
      if (mismatches == 0 && due_words.size() == 0) begin
         $display("PASS csv_field_splitter");
      end else begin
         $display("FAIL csv_field_splitter");
      end
      $finish;
   end

endmodule

@@ files.f @@
rtl/core/cfs_pkg.sv
rtl/core/cfs_step.sv
rtl/core/cfs_ctrl.sv
rtl/core/csv_field_splitter.sv
tb/sv/tb_csv_field_splitter.sv
